FILE: rtl/i3wf_pkg.sv
// ---------------------------------------------------------------------------
// i3wf_pkg: shared types and constants of the 3x3 window filter
// Sizes of the line stores and counters, filter mode codes, register
// indexes and the packed words that cross module boundaries.
// ---------------------------------------------------------------------------
`default_nettype none

package i3wf_pkg;

	// Frame geometry limits.
	localparam int MAX_WIDTH    = 1024;
	localparam int PIXEL_BITS   = 8;
	localparam int HEIGHT_LIMIT = 4096;

	// Register field widths as seen on the configuration port.
	localparam int MODE_W   = 2;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;

	// Counter widths: a column address, a width value and a row count.
	localparam int COL_AW = $clog2(MAX_WIDTH);
	localparam int COL_CW = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W  = $clog2(HEIGHT_LIMIT + 1);
	localparam int EMIT_W = $clog2(MAX_WIDTH * HEIGHT_LIMIT);
	localparam int DIV_CW = $clog2(EMIT_W + 1);

	// Configuration port.
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Kernel arithmetic widths.
	localparam int WIN_TAPS  = 9;
	localparam int LAP_GAIN  = 4;
	localparam int ROW_SUM_W = PIXEL_BITS + 2;
	localparam int SUM_W     = PIXEL_BITS + 4;
	localparam int LAP_W     = PIXEL_BITS + 4;
	localparam int SHARP_W   = PIXEL_BITS + 5;

	// Division by nine as a multiplication by a rounded-up reciprocal.
	// Exact for every dividend below two to the power of the shift.
	localparam int RECIP_SHIFT = 15;
	localparam int RECIP_NINE  = ((1 << RECIP_SHIFT) + WIN_TAPS - 1) / WIN_TAPS;
	localparam int RECIP_W     = $clog2(RECIP_NINE + 1);
	localparam int PROD_W      = SUM_W + RECIP_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_INVERT  = 2'd0,
		MODE_BOX     = 2'd1,
		MODE_EDGE    = 2'd2,
		MODE_SHARPEN = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE     = 2'd0,
		REG_WIDTH    = 2'd1,
		REG_HEIGHT   = 2'd2,
		REG_GRAY_MAX = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] in_pixel;
		logic                  is_flush;
	} in_word_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] out_pixel;
		logic                  frame_last;
	} out_word_t;

	// One new column of the window: rows above, middle and current.
	typedef struct packed {
		logic [PIXEL_BITS-1:0] up;
		logic [PIXEL_BITS-1:0] mid;
		logic [PIXEL_BITS-1:0] pix;
	} col_word_t;

	// Per-item control decided when the item is accepted.
	typedef struct packed {
		logic result;
		logic border;
		logic last;
	} item_ctl_t;

	typedef struct packed {
		logic      valid;
		col_word_t col;
		item_ctl_t ctl;
	} kern_in_t;

endpackage

`default_nettype wire

FILE: rtl/i3wf_ram.sv
// ---------------------------------------------------------------------------
// i3wf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data. A read at
// the address being written returns the old contents.
// ---------------------------------------------------------------------------
`default_nettype none

module i3wf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read share the clock.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/i3wf_kernel.sv
// ---------------------------------------------------------------------------
// i3wf_kernel: 3x3 window and filter arithmetic
// Shifts a new column into the window, forms the sums in one stage and
// the divided, clamped and selected result in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module i3wf_kernel (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  i3wf_pkg::kern_in_t              kin,
	input  i3wf_pkg::mode_t                 mode,
	input  logic [i3wf_pkg::PIXEL_BITS-1:0] gray_max,
	output logic                            out_valid,
	output i3wf_pkg::out_word_t             out_data
);

	import i3wf_pkg::*;

	logic [PIXEL_BITS-1:0] win_q [3][3];
	logic [PIXEL_BITS-1:0] nw [3][3];
	logic [ROW_SUM_W-1:0]  row_sum [3];
	logic [SUM_W-1:0]      sum9;
	logic [LAP_W-1:0]      lap_pos;
	logic [LAP_W-1:0]      lap_neg;
	logic [LAP_W-1:0]      lap;
	logic [SHARP_W-1:0]    sharp;

	logic                  s2_valid;
	logic [PIXEL_BITS-1:0] p_s2;
	logic [SUM_W-1:0]      sum_s2;
	logic [LAP_W-1:0]      lap_s2;
	logic [SHARP_W-1:0]    sharp_s2;
	logic                  border_s2;
	logic                  last_s2;

	logic [LAP_W-1:0]      lap_abs;
	logic [SUM_W-1:0]      div_in;
	logic [PROD_W-1:0]     prod;
	logic [PIXEL_BITS-1:0] quot;
	logic [PIXEL_BITS-1:0] inv;
	logic [PIXEL_BITS-1:0] clamp;
	logic [PIXEL_BITS-1:0] value;

	// Window after this item's column has been shifted in.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			nw[r][0] = win_q[r][1];
			nw[r][1] = win_q[r][2];
		end
		nw[0][2] = kin.col.up;
		nw[1][2] = kin.col.mid;
		nw[2][2] = kin.col.pix;
	end

	// Sums for box mean, Laplacian and sharpen, as a small adder tree.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			row_sum[r] = ROW_SUM_W'(nw[r][0]) + ROW_SUM_W'(nw[r][1])
				+ ROW_SUM_W'(nw[r][2]);
		end
		sum9 = SUM_W'(row_sum[0]) + SUM_W'(row_sum[1]) + SUM_W'(row_sum[2]);
		lap_pos = LAP_W'(nw[1][1]) * LAP_W'(LAP_GAIN);
		lap_neg = LAP_W'(nw[0][1]) + LAP_W'(nw[2][1]) + LAP_W'(nw[1][0])
			+ LAP_W'(nw[1][2]);
		lap = lap_pos - lap_neg;
		sharp = SHARP_W'(nw[1][1]) * SHARP_W'(WIN_TAPS)
			- (SHARP_W'(sum9) - SHARP_W'(nw[1][1]));
	end

	// Window and sum stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (adv) begin
			s2_valid <= kin.valid && kin.ctl.result;
			if (kin.valid) begin
				win_q     <= nw;
				p_s2      <= nw[1][1];
				sum_s2    <= sum9;
				lap_s2    <= lap;
				sharp_s2  <= sharp;
				border_s2 <= kin.ctl.border;
				last_s2   <= kin.ctl.last;
			end
		end
	end

	// Division by nine is shared between box mean and Laplacian.
	always_comb begin
		lap_abs = lap_s2[LAP_W-1] ? (~lap_s2 + LAP_W'(1)) : lap_s2;
		div_in  = (mode == MODE_BOX) ? sum_s2 : SUM_W'(lap_abs);
		prod    = PROD_W'(div_in) * PROD_W'(RECIP_NINE);
		quot    = prod[RECIP_SHIFT +: PIXEL_BITS];
		inv     = gray_max - p_s2;
	end

	// Sharpen result is clamped to the gray range.
	always_comb begin
		if (sharp_s2[SHARP_W-1]) begin
			clamp = '0;
		end else if (sharp_s2[SHARP_W-2:0] > (SHARP_W-1)'(gray_max)) begin
			clamp = gray_max;
		end else begin
			clamp = sharp_s2[PIXEL_BITS-1:0];
		end
	end

	// Mode selection; border pixels copy the centre or give zero.
	always_comb begin
		unique case (mode)
			MODE_INVERT:  value = inv;
			MODE_BOX:     value = border_s2 ? p_s2 : quot;
			MODE_EDGE:    value = border_s2 ? '0 : quot;
			MODE_SHARPEN: value = border_s2 ? '0 : clamp;
			default:      value = inv;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= s2_valid;
			if (s2_valid) begin
				out_data.out_pixel  <= value;
				out_data.frame_last <= last_s2;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/image_3x3_window_filter_top.sv
// ---------------------------------------------------------------------------
// image_3x3_window_filter_top: streaming 3x3 window filter for gray pixels
// Pixels enter in raster order on the in_valid/in_ready channel; filtered
// pixels leave in raster order on out_valid/out_ready, one row plus one
// pixel behind the input. After the last pixel of a frame the sender
// pushes the tail out with image_width+1 flush words; the word for the
// last pixel of the frame carries frame_last.
// One input word can be taken every cycle while in_ready is high; a result
// is registered in the first stage, the window and sum stage and then the
// output register. While a result waits there with out_ready low, the
// pipeline holds and in_ready is low; an empty output register never
// blocks the input. Writing image_width holds in_ready low while a
// bit-serial divider re-derives the output row and column from the count of
// results already given. Registers sit on an APB-style port, four words at
// byte addresses 0, 4, 8 and 12.
// Reset clears the counters, the window and the registers to their reset
// values. The two line stores are not cleared; an entry read before it is
// written within a frame feeds only border results, which do not use it.
// ---------------------------------------------------------------------------
`default_nettype none

module image_3x3_window_filter_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [i3wf_pkg::APB_AW-1:0] paddr,
	input  logic [i3wf_pkg::APB_DW-1:0] pwdata,
	output logic [i3wf_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  i3wf_pkg::in_word_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output i3wf_pkg::out_word_t         out_data
);

	import i3wf_pkg::*;

	// Configuration registers.
	mode_t                 mode_q;
	logic [WIDTH_W-1:0]    width_q;
	logic [HEIGHT_W-1:0]   height_q;
	logic [PIXEL_BITS-1:0] gray_q;
	logic                  cfg_we;
	reg_idx_t              cfg_idx;

	logic [COL_CW-1:0]     w_eff;
	logic [ROW_W-1:0]      h_eff;

	// Input and output position counters.
	logic [COL_AW-1:0]     col_q;
	logic [ROW_W-1:0]      row_q;
	logic [EMIT_W-1:0]     emitted_q;
	logic [EMIT_W-1:0]     er_q;
	logic [COL_AW-1:0]     ec_q;

	// Handshake and next-state terms.
	logic                  adv;
	logic                  acc;
	logic                  idle_flush;
	logic                  wrap0;
	logic [COL_AW-1:0]     c0;
	logic [ROW_W-1:0]      r0;
	logic [COL_CW-1:0]     c1;
	logic [COL_AW-1:0]     col_n;
	logic [ROW_W-1:0]      row_n;
	logic                  flush_eff;
	logic [PIXEL_BITS-1:0] pix;
	logic                  emit;
	logic                  frame_done;
	logic [EMIT_W-1:0]     h_m1;
	logic [COL_CW-1:0]     w_m1;
	logic [COL_CW-1:0]     ec_x;
	logic [COL_CW-1:0]     ec_inc;
	item_ctl_t             ctl;

	// First pipeline stage: store read and column forwarding.
	logic                  valid_s1;
	logic [COL_AW-1:0]     addr_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	item_ctl_t             ctl_s1;
	logic                  fwd_s1;
	logic [PIXEL_BITS-1:0] fwd_up_s1;
	logic [PIXEL_BITS-1:0] fwd_mid_s1;
	logic [PIXEL_BITS-1:0] up_rd;
	logic [PIXEL_BITS-1:0] mid_rd;
	logic [PIXEL_BITS-1:0] up_eff;
	logic [PIXEL_BITS-1:0] mid_eff;
	logic                  store_we;
	kern_in_t              kin;

	// Serial divider for the output position after a width change.
	logic                  div_busy_q;
	logic [DIV_CW-1:0]     div_cnt_q;
	logic [EMIT_W-1:0]     div_num_q;
	logic [COL_AW-1:0]     div_rem_q;
	logic [COL_CW:0]       div_t;
	logic                  div_ge;
	logic [COL_AW-1:0]     div_rem_n;

	// Register port: writes complete in the access cycle.
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_MODE:     prdata = APB_DW'(mode_q);
			REG_WIDTH:    prdata = APB_DW'(width_q);
			REG_HEIGHT:   prdata = APB_DW'(height_q);
			REG_GRAY_MAX: prdata = APB_DW'(gray_q);
			default:      prdata = '0;
		endcase
	end

	// Frame size with out-of-range values folded into the legal range.
	always_comb begin
		if (width_q == '0) begin
			w_eff = COL_CW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = COL_CW'(MAX_WIDTH);
		end else begin
			w_eff = COL_CW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = ROW_W'(1);
		end else if (32'(height_q) > HEIGHT_LIMIT) begin
			h_eff = ROW_W'(HEIGHT_LIMIT);
		end else begin
			h_eff = ROW_W'(height_q);
		end
	end

	// The pipeline moves whenever the output register can take a word.
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv && !div_busy_q;
	assign acc      = in_valid && in_ready;

	// Position of the incoming word and of the result it releases.
	always_comb begin
		idle_flush = in_data.is_flush && (row_q == '0) && (col_q == '0)
			&& (emitted_q == '0);
		wrap0     = COL_CW'(col_q) >= w_eff;
		c0        = wrap0 ? '0 : col_q;
		r0        = wrap0 ? ROW_W'(row_q + 1'b1) : row_q;
		flush_eff = in_data.is_flush || (r0 >= h_eff);
		pix       = flush_eff ? '0 : in_data.in_pixel;
		emit      = (r0 > ROW_W'(1)) || ((r0 == ROW_W'(1)) && (c0 != '0));
		c1        = COL_CW'(c0) + COL_CW'(1);
		if (c1 >= w_eff) begin
			col_n = '0;
			row_n = ROW_W'(r0 + 1'b1);
		end else begin
			col_n = c1[COL_AW-1:0];
			row_n = r0;
		end

		h_m1       = EMIT_W'(h_eff) - EMIT_W'(1);
		w_m1       = w_eff - COL_CW'(1);
		ec_x       = COL_CW'(ec_q);
		ec_inc     = ec_x + COL_CW'(1);
		frame_done = er_q >= EMIT_W'(h_eff);

		ctl.result = emit && !frame_done;
		ctl.border = (er_q == '0) || (ec_q == '0) || (er_q >= h_m1) || (ec_x >= w_m1);
		ctl.last   = (er_q == h_m1) && (ec_x >= w_m1);
	end

	// Divider step: one quotient bit per cycle.
	always_comb begin
		div_t     = (COL_CW+1)'({div_rem_q, div_num_q[EMIT_W-1]});
		div_ge    = div_t >= (COL_CW+1)'(w_eff);
		div_rem_n = div_ge ? COL_AW'(div_t - (COL_CW+1)'(w_eff)) : COL_AW'(div_t);
	end

	// Registers, counters and the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_INVERT;
			width_q    <= WIDTH_W'(MAX_WIDTH);
			height_q   <= HEIGHT_W'(1);
			gray_q     <= '1;
			col_q      <= '0;
			row_q      <= '0;
			emitted_q  <= '0;
			er_q       <= '0;
			ec_q       <= '0;
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_MODE:     mode_q   <= mode_t'(pwdata[MODE_W-1:0]);
					REG_WIDTH:    width_q  <= pwdata[WIDTH_W-1:0];
					REG_HEIGHT:   height_q <= pwdata[HEIGHT_W-1:0];
					REG_GRAY_MAX: gray_q   <= pwdata[PIXEL_BITS-1:0];
					default:      ;
				endcase
			end

			if (cfg_we && (cfg_idx == REG_WIDTH)) begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= DIV_CW'(EMIT_W);
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q - DIV_CW'(1);
				if (div_cnt_q == DIV_CW'(1)) begin
					div_busy_q <= 1'b0;
					er_q       <= {div_num_q[EMIT_W-2:0], div_ge};
					ec_q       <= div_rem_n;
				end
			end

			if (acc && !idle_flush) begin
				col_q <= col_n;
				row_q <= row_n;
				if (emit) begin
					if (frame_done || ctl.last) begin
						col_q     <= '0;
						row_q     <= '0;
						emitted_q <= '0;
						er_q      <= '0;
						ec_q      <= '0;
					end else begin
						emitted_q <= emitted_q + 1'b1;
						if (ec_inc >= w_eff) begin
							ec_q <= '0;
							er_q <= er_q + 1'b1;
						end else begin
							ec_q <= ec_inc[COL_AW-1:0];
						end
					end
				end
			end
		end
	end

	// Divider data path holds no control state.
	always_ff @(posedge clk) begin
		if (cfg_we && (cfg_idx == REG_WIDTH)) begin
			div_num_q <= emitted_q;
			div_rem_q <= '0;
		end else if (div_busy_q) begin
			div_num_q <= {div_num_q[EMIT_W-2:0], div_ge};
			div_rem_q <= div_rem_n;
		end
	end

	// First stage valid bit follows the pipeline advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc && !idle_flush;
		end
	end

	// First stage payload. If the word leaving this stage writes the column
	// being read, the store still returns the old entry, so keep the new one.
	always_ff @(posedge clk) begin
		if (acc) begin
			addr_s1    <= c0;
			pix_s1     <= pix;
			ctl_s1     <= ctl;
			fwd_s1     <= valid_s1 && (addr_s1 == c0);
			fwd_up_s1  <= mid_eff;
			fwd_mid_s1 <= pix_s1;
		end
	end

	assign up_eff   = fwd_s1 ? fwd_up_s1 : up_rd;
	assign mid_eff  = fwd_s1 ? fwd_mid_s1 : mid_rd;
	assign store_we = valid_s1 && adv;

	// Line store for the row two above the current one.
	i3wf_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_store_upper (
		.clk  (clk),
		.we   (store_we),
		.waddr(addr_s1),
		.wdata(mid_eff),
		.re   (acc),
		.raddr(c0),
		.rdata(up_rd)
	);

	// Line store for the row directly above the current one.
	i3wf_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_store_middle (
		.clk  (clk),
		.we   (store_we),
		.waddr(addr_s1),
		.wdata(pix_s1),
		.re   (acc),
		.raddr(c0),
		.rdata(mid_rd)
	);

	// Window, filter arithmetic and output register.
	always_comb begin
		kin.valid   = valid_s1;
		kin.col.up  = up_eff;
		kin.col.mid = mid_eff;
		kin.col.pix = pix_s1;
		kin.ctl     = ctl_s1;
	end

	i3wf_kernel u_kernel (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.kin      (kin),
		.mode     (mode_q),
		.gray_max (gray_q),
		.out_valid(out_valid),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the streaming 3x3 window filter
// Streams raster frames of gray pixels through image_3x3_window_filter_top
// with random gaps on the input and random stalls on the output. A
// cycle-free model of the line stores, the window and the frame counters
// predicts every filtered pixel. Each output word is checked field by
// field against the oldest prediction. Registers are changed over the
// APB-style port only between frames, while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import i3wf_pkg::*;

	typedef enum int {PIX_NOISE, PIX_STARK, PIX_SMOOTH} pixel_style_t;

	logic clk;
	logic arst_n = 1'b0;

	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	// Words waiting to be sent and filtered pixels waiting to come out.
	in_word_t  pending_words [$];
	out_word_t expected_pixels [$];

	// Register copies held by the predictor.
	mode_t       cfg_mode = MODE_INVERT;
	logic [10:0] cfg_width = 11'd1024;
	logic [12:0] cfg_height = 13'd1;
	logic [7:0]  cfg_gray = 8'd255;

	// Predictor state: line stores, window and frame counters.
	logic [7:0] upper_row [MAX_WIDTH];
	logic [7:0] middle_row [MAX_WIDTH];
	logic [7:0] win [3][3] = '{default: '0};
	int         col_pos = 0;
	int         row_pos = 0;
	int         done_count = 0;

	bit steady_flow = 1'b0;
	int mismatches = 0;
	int words_taken = 0;
	int pixels_checked = 0;
	int frames_run = 0;
	int stim_words = 0;

	image_3x3_window_filter_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// A run that has not ended by now is stuck.
	initial begin
		#15_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Each mismatch prints one line and is counted.
	task automatic note_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic int frame_width();
		if (cfg_width == 0) return 1;
		if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
		return int'(cfg_width);
	endfunction

	function automatic int frame_height();
		if (cfg_height == 0) return 1;
		if (cfg_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
		return int'(cfg_height);
	endfunction

	// Advances the filter state by one accepted word and returns 1 when the
	// word pushes out a filtered pixel, which is then placed in res.
	function automatic bit predict_pixel(input in_word_t w, output out_word_t res);
		int wid, hgt, total, col, r, c, i, j, ctr, sum8, v, gmax;
		int tap [3][3];
		bit flush, emit, border;
		logic [7:0] pix;
		wid = frame_width();
		hgt = frame_height();
		total = wid * hgt;
		gmax = cfg_gray;
		flush = w.is_flush;
		res = '0;

		// A flush word with nothing of a frame received yet is dropped.
		if (flush && row_pos == 0 && col_pos == 0 && done_count == 0)
			return 1'b0;
		if (col_pos >= wid) begin
			col_pos = 0;
			row_pos++;
		end
		col = col_pos;

		// Past the last row every word counts as a flush word.
		if (row_pos > hgt - 1)
			flush = 1'b1;
		pix = flush ? 8'd0 : w.in_pixel;

		for (i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = upper_row[col];
		win[1][2] = middle_row[col];
		win[2][2] = pix;
		upper_row[col] = win[1][2];
		middle_row[col] = pix;

		emit = (row_pos > 1) || (row_pos == 1 && col >= 1);
		col_pos = col + 1;
		if (col_pos >= wid) begin
			col_pos = 0;
			row_pos++;
		end
		if (!emit || done_count >= total) begin
			if (emit) begin
				row_pos = 0;
				col_pos = 0;
				done_count = 0;
			end
			return 1'b0;
		end

		r = done_count / wid;
		c = done_count % wid;
		border = (r == 0) || (c == 0) || (r >= hgt - 1) || (c >= wid - 1);
		sum8 = 0;
		for (i = 0; i < 3; i++)
			for (j = 0; j < 3; j++) begin
				tap[i][j] = win[i][j];
				sum8 += tap[i][j];
			end
		ctr = tap[1][1];
		sum8 -= ctr;

		case (cfg_mode)
		MODE_INVERT: res.out_pixel = cfg_gray - win[1][1];
		MODE_BOX: res.out_pixel = border ? win[1][1] : 8'((sum8 + ctr) / 9);
		MODE_EDGE: begin
			v = (4 * ctr - tap[0][1] - tap[2][1] - tap[1][0] - tap[1][2]) / 9;
			if (v < 0) v = -v;
			res.out_pixel = border ? 8'd0 : 8'(v);
		end
		default: begin
			v = 9 * ctr - sum8;
			if (v < 0) v = 0;
			if (v > gmax) v = gmax;
			res.out_pixel = border ? 8'd0 : 8'(v);
		end
		endcase

		res.frame_last = (done_count + 1 >= total);
		done_count++;
		if (res.frame_last) begin
			row_pos = 0;
			col_pos = 0;
			done_count = 0;
		end
		return 1'b1;
	endfunction

	function automatic int draw_wait();
		if (steady_flow || $urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic logic [7:0] draw_pixel(input pixel_style_t style, input int base);
		int t;
		case (style)
		PIX_NOISE: return 8'($urandom);
		PIX_STARK: begin
			t = $urandom_range(0, 2);
			return (t == 0) ? 8'h00 : ((t == 1) ? 8'hFF : 8'(base));
		end
		default: begin
			t = base + int'($urandom_range(0, 16)) - 8;
			if (t < 0) t = 0;
			if (t > 255) t = 255;
			return 8'(t);
		end
		endcase
	endfunction

	// Input driver: one word at a time from the pending queue, with a drawn
	// gap after each accepted word.
	always @(posedge clk) begin
		bit live;
		int gap_left;
		out_word_t res;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			live = in_valid;
			if (in_valid && in_ready) begin
				if (predict_pixel(in_data, res))
					expected_pixels.push_back(res);
				words_taken++;
				live = 1'b0;
				gap_left = draw_wait();
			end
			if (!live) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_words.size() > 0) begin
					in_data <= pending_words.pop_front();
					live = 1'b1;
				end
			end
			in_valid <= live;
		end
	end

	// Output monitor: checks each word taken and stalls for a drawn time
	// after it.
	always @(posedge clk) begin
		out_word_t want;
		int stall_left;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					note_mismatch($sformatf("unexpected output word %h", out_data));
				end else begin
					want = expected_pixels.pop_front();
					if (out_data.out_pixel !== want.out_pixel)
						note_mismatch($sformatf("pixel %0d: out_pixel %0d, expected %0d",
							pixels_checked, out_data.out_pixel, want.out_pixel));
					if (out_data.frame_last !== want.frame_last)
						note_mismatch($sformatf("pixel %0d: frame_last %b, expected %b",
							pixels_checked, out_data.frame_last, want.frame_last));
				end
				pixels_checked++;
				stall_left = draw_wait();
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic queue_word(input bit flush, input logic [7:0] px);
		in_word_t w;
		w.in_pixel = px;
		w.is_flush = flush;
		pending_words.push_back(w);
		stim_words++;
	endtask

	// Returns at a falling edge once every word is sent and every pixel is out.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0);
	endtask

	// Finishes a frame left open with single flush words, then lets the
	// pipeline and any width divider run out before registers change.
	task automatic settle_frame();
		wait_drained();
		while (row_pos != 0 || col_pos != 0 || done_count != 0) begin
			queue_word(1'b1, 8'($urandom));
			wait_drained();
		end
		repeat (30) @(negedge clk);
	endtask

	// Writes a register, reads it back and updates the predictor's copy.
	task automatic set_reg(input reg_idx_t idx, input int unsigned val);
		logic [APB_DW-1:0] mask;
		case (idx)
		REG_MODE:   mask = 32'h3;
		REG_WIDTH:  mask = 32'h7FF;
		REG_HEIGHT: mask = 32'h1FFF;
		default:    mask = 32'hFF;
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (prdata !== (val & mask))
			note_mismatch($sformatf("register %s reads %h, expected %h",
				idx.name(), prdata, val & mask));
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
		REG_MODE:   cfg_mode = mode_t'(val & mask);
		REG_WIDTH:  cfg_width = 11'(val & mask);
		REG_HEIGHT: cfg_height = 13'(val & mask);
		default:    cfg_gray = 8'(val & mask);
		endcase
		@(negedge clk);
	endtask

	// Brings the block to a frame start and writes the registers that change,
	// plus now and then one that does not.
	task automatic setup_frame(input mode_t m, input int unsigned w, input int unsigned h,
			input int unsigned g);
		settle_frame();
		if (m != cfg_mode || $urandom_range(0, 3) == 0) set_reg(REG_MODE, m);
		if (w != cfg_width || $urandom_range(0, 3) == 0) set_reg(REG_WIDTH, w);
		if (h != cfg_height || $urandom_range(0, 3) == 0) set_reg(REG_HEIGHT, h);
		if (g != cfg_gray || $urandom_range(0, 3) == 0) set_reg(REG_GRAY_MAX, g);
		frames_run++;
	endtask

	// Queues one frame and its flush tail. A noisy frame gets early flush
	// words, late pixels in the tail, a cut tail, a stray flush afterwards
	// and now and then a pause until everything has come out.
	task automatic run_frame(input pixel_style_t style, input bit noisy);
		int wid, hgt, n, tail, idx, pause_at, base;
		wid = frame_width();
		hgt = frame_height();
		n = wid * hgt;
		tail = wid + 1;
		base = $urandom_range(0, 255);
		pause_at = (noisy && $urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
		for (idx = 0; idx < n; idx++) begin
			if (idx == pause_at) wait_drained();
			if (noisy && $urandom_range(0, 39) == 0)
				queue_word(1'b1, 8'($urandom));
			else
				queue_word(1'b0, draw_pixel(style, base));
		end
		if (noisy && $urandom_range(0, 9) == 0) tail = $urandom_range(0, wid);
		for (idx = 0; idx < tail; idx++)
			queue_word(!noisy || $urandom_range(0, 9) != 0, 8'($urandom));
		if (noisy && $urandom_range(0, 4) == 0)
			queue_word(1'b1, 8'($urandom));
	endtask

	initial begin
		logic [7:0] sharpen_scene [12];
		int i, wid, hgt, gmax, pick;
		sharpen_scene = '{8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd255,
			8'd0, 8'd60, 8'd70, 8'd80, 8'd255, 8'd90};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A flush word straight after reset is dropped.
		queue_word(1'b1, 8'hA5);

		// Sharpen on a 4x3 frame: one inner pixel clamps at gray_max, the other
		// at zero. Row 2 opens with an early flush, the sender waits for all
		// results before it, and the tail starts with a late pixel.
		setup_frame(MODE_SHARPEN, 4, 3, 200);
		for (i = 0; i < 12; i++) begin
			if (i == 8) wait_drained();
			queue_word(i == 8, sharpen_scene[i]);
		end
		queue_word(1'b0, 8'hFF);
		repeat (4) queue_word(1'b1, 8'h5A);

		// Zero width and height count as one; invert wraps with gray_max zero.
		setup_frame(MODE_INVERT, 0, 0, 0);
		queue_word(1'b0, 8'hFF);
		repeat (2) queue_word(1'b1, 8'h00);

		// Frames too thin to have an inner pixel: all border.
		setup_frame(MODE_BOX, 2, 1, 255);
		queue_word(1'b0, 8'h00);
		queue_word(1'b0, 8'hFF);
		repeat (3) queue_word(1'b1, 8'hFF);
		setup_frame(MODE_EDGE, 1, 2, 255);
		queue_word(1'b0, 8'h7F);
		queue_word(1'b0, 8'h80);
		repeat (3) queue_word(1'b1, 8'h01);

		// Random small frames in every mode.
		while (stim_words < 1350) begin
			steady_flow = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 15);
			wid = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(13, 64) :
				(pick == 2) ? 1 : $urandom_range(2, 12);
			pick = $urandom_range(0, 11);
			hgt = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			pick = $urandom_range(0, 7);
			gmax = (pick == 0) ? 0 : (pick < 3) ? 255 : $urandom_range(1, 254);
			setup_frame(mode_t'($urandom_range(0, 3)), wid, hgt, gmax);
			run_frame(pixel_style_t'($urandom_range(0, 2)), 1'b1);
		end
		steady_flow = 1'b0;

		wait_drained();
		repeat (30) @(negedge clk);
		if (expected_pixels.size() != 0)
			note_mismatch($sformatf("%0d pixels never came out", expected_pixels.size()));
		$display("Sent %0d words in %0d frames over all four modes; %0d pixels checked.",
			words_taken, frames_run, pixels_checked);
		$display("Frames ranged from one pixel to 64-pixel rows, zero sizes folded to one.");
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
